@@ rtl/tfsb_pkg.sv @@
// Types, codes and constants shared by the timestamp frame sync buffer modules.
package tfsb_pkg;

  localparam int unsigned STAMP_W  = 63;
  localparam int unsigned FH_W     = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned CFG_W    = 5;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd15;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_SHOW  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_STORED       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_STORED_SHOWN = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXACT        = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NEAREST      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY        = 3'd4;

  typedef struct packed {
    logic               kind;
    logic [STAMP_W-1:0] stamp;
    logic [FH_W-1:0]    frame_handle;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                shown;
    logic [STAMP_W-1:0]  shown_stamp;
    logic [FH_W-1:0]     shown_handle;
    logic [OCC_W-1:0]    occupancy;
  } out_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SET_HANDLE,
    OP_INS_RIGHT,
    OP_INS_LEFT,
    OP_SHIFT_LEFT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PICK,
    ST_DRAIN,
    ST_EVICT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } flag_t;

  typedef struct packed {
    cell_op_e           op;
    logic               load;
    logic [STAMP_W-1:0] key;
  } cell_ctl_t;

endpackage

@@ rtl/tfsb_cell.sv @@
// One slot of the sorted entry chain: holds an entry, its compare flags, and shifts with neighbors.
module tfsb_cell #(
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tfsb_pkg::cell_ctl_t      ctl_i,
  input  logic [HANDLE_BITS-1:0]   key_handle_i,
  input  tfsb_pkg::entry_t         left_entry_i,
  input  logic [HANDLE_BITS-1:0]   left_handle_i,
  input  tfsb_pkg::flag_t          left_flag_i,
  input  tfsb_pkg::entry_t         right_entry_i,
  input  logic [HANDLE_BITS-1:0]   right_handle_i,
  input  tfsb_pkg::flag_t          right_flag_i,
  output tfsb_pkg::entry_t         entry_o,
  output logic [HANDLE_BITS-1:0]   handle_o,
  output tfsb_pkg::flag_t          flag_o
);

  logic                         valid_q, valid_d;
  logic [tfsb_pkg::STAMP_W-1:0] stamp_q, stamp_d;
  logic [HANDLE_BITS-1:0]       handle_q, handle_d;
  tfsb_pkg::flag_t              flag_q, flag_d;

  always_comb begin
    flag_d = flag_q;
    if (ctl_i.load) begin
      flag_d.lt = valid_q && (stamp_q < ctl_i.key);
      flag_d.eq = valid_q && (stamp_q == ctl_i.key);
      flag_d.gt = valid_q && (stamp_q > ctl_i.key);
    end
  end

  always_comb begin
    valid_d  = valid_q;
    stamp_d  = stamp_q;
    handle_d = handle_q;
    case (ctl_i.op)
      tfsb_pkg::OP_HOLD: begin
      end
      tfsb_pkg::OP_SET_HANDLE: begin
        if (flag_q.eq) begin
          handle_d = key_handle_i;
        end
      end
      tfsb_pkg::OP_INS_RIGHT: begin
        if (!left_flag_i.lt) begin
          valid_d  = left_entry_i.valid;
          stamp_d  = left_entry_i.stamp;
          handle_d = left_handle_i;
        end else if (!flag_q.lt) begin
          valid_d  = 1'b1;
          stamp_d  = ctl_i.key;
          handle_d = key_handle_i;
        end
      end
      tfsb_pkg::OP_INS_LEFT: begin
        if (right_flag_i.lt) begin
          valid_d  = right_entry_i.valid;
          stamp_d  = right_entry_i.stamp;
          handle_d = right_handle_i;
        end else if (flag_q.lt) begin
          valid_d  = 1'b1;
          stamp_d  = ctl_i.key;
          handle_d = key_handle_i;
        end
      end
      tfsb_pkg::OP_SHIFT_LEFT: begin
        valid_d  = right_entry_i.valid;
        stamp_d  = right_entry_i.stamp;
        handle_d = right_handle_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flag_q  <= '0;
    end else begin
      valid_q <= valid_d;
      flag_q  <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q  <= stamp_d;
    handle_q <= handle_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.stamp = stamp_q;
  assign handle_o      = handle_q;
  assign flag_o        = flag_q;

endmodule

@@ rtl/timestamp_frame_sync_buffer_core.sv @@
// Top level of the timestamp frame sync buffer: sorted cell chain, sequencer and result register.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i / in_stall_o   tfsb_pkg::in_t
//   out      output     out_valid_o / out_stall_i tfsb_pkg::out_t
//   cfg      input      cfg_we_i                  cfg_wdata_i (capacity limit)
//
// Entries sit in the cell chain sorted by stamp, packed from cell 0 (smallest).
// Store: DECIDE, then EVICT when a stamp already held is rewritten over the limit, then DONE.
// Show: DECIDE, PICK, DRAIN over the entries discarded, then DONE; DRAIN is skipped on an empty store.
// The discard runs through cell 0, one entry shifted out per cycle.
// Reset empties the chain, sets auto-show and a limit of 15.
// The result waits in the output register; a new transaction is taken meanwhile.
module timestamp_frame_sync_buffer_core #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  tfsb_pkg::in_t                  in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output tfsb_pkg::out_t                 out_o,
  input  logic                           cfg_we_i,
  input  logic [tfsb_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned LW    = (CNT_W > tfsb_pkg::CFG_W) ? CNT_W : tfsb_pkg::CFG_W;
  localparam int unsigned SW    = tfsb_pkg::STAMP_W;
  localparam int unsigned FHW   = tfsb_pkg::FH_W;
  localparam int unsigned OCCW  = tfsb_pkg::OCC_W;

  tfsb_pkg::state_e state_q, state_d;

  logic                          kind_q;
  logic [SW-1:0]                 key_q;
  logic [HANDLE_BITS-1:0]        khandle_q;
  logic                          auto_q, auto_d;
  logic [CNT_W-1:0]              n_q, n_d;
  logic [tfsb_pkg::CFG_W-1:0]    lim_q, lim_d;

  logic [tfsb_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic                          res_shown_q, res_shown_d;
  logic [SW-1:0]                 res_stamp_q, res_stamp_d;
  logic [HANDLE_BITS-1:0]        res_handle_q, res_handle_d;

  logic                          hit_q, hit_d;
  logic                          has_below_q, has_below_d;
  logic                          has_above_q, has_above_d;
  logic [SW-1:0]                 below_stamp_q, below_stamp_d;
  logic [SW-1:0]                 above_stamp_q, above_stamp_d;
  logic [HANDLE_BITS-1:0]        below_handle_q, below_handle_d;
  logic [HANDLE_BITS-1:0]        above_handle_q, above_handle_d;
  logic [HANDLE_BITS-1:0]        hit_handle_q, hit_handle_d;

  tfsb_pkg::out_t                out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  tfsb_pkg::cell_op_e            cell_op;
  tfsb_pkg::cell_ctl_t           cell_ctl;
  tfsb_pkg::entry_t              cell_entry  [DEPTH];
  logic [HANDLE_BITS-1:0]        cell_handle [DEPTH];
  tfsb_pkg::flag_t               cell_flag   [DEPTH];

  logic [DEPTH-1:0]              valid_vec;
  logic [DEPTH-1:0]              eq_vec;
  logic [DEPTH-1:0]              below_oh;
  logic [DEPTH-1:0]              above_oh;

  logic                          in_acc;
  logic                          out_free;
  logic                          hit_any;
  logic                          full;
  logic [LW-1:0]                 lim_ext;
  logic [LW-1:0]                 eff_lim;
  logic [LW-1:0]                 n_ext;
  logic                          over_lim;
  logic                          at_lim;
  logic                          drain_go;
  logic                          pick_empty;
  logic [SW:0]                   pair_sum;
  logic                          pick_below;

  logic [SW-1:0]                 sel_below_stamp;
  logic [SW-1:0]                 sel_above_stamp;
  logic [HANDLE_BITS-1:0]        sel_below_handle;
  logic [HANDLE_BITS-1:0]        sel_above_handle;
  logic [HANDLE_BITS-1:0]        sel_hit_handle;

  assign in_stall_o = (state_q != tfsb_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cell_ctl.op   = cell_op;
  assign cell_ctl.load = in_acc;
  assign cell_ctl.key  = in_acc ? in_i.stamp : key_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tfsb_pkg::entry_t       left_entry, right_entry;
    logic [HANDLE_BITS-1:0] left_handle, right_handle;
    tfsb_pkg::flag_t        left_flag, right_flag;

    if (i == 0) begin : g_first
      assign left_entry  = '0;
      assign left_handle = '0;
      assign left_flag   = '{lt: 1'b1, eq: 1'b0, gt: 1'b0};
      assign above_oh[i] = cell_flag[i].gt;
    end else begin : g_mid_l
      assign left_entry  = cell_entry[i-1];
      assign left_handle = cell_handle[i-1];
      assign left_flag   = cell_flag[i-1];
      assign above_oh[i] = cell_flag[i].gt && !cell_flag[i-1].gt;
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
      assign right_handle = '0;
      assign right_flag  = '0;
      assign below_oh[i] = cell_flag[i].lt;
    end else begin : g_mid_r
      assign right_entry  = cell_entry[i+1];
      assign right_handle = cell_handle[i+1];
      assign right_flag   = cell_flag[i+1];
      assign below_oh[i]  = cell_flag[i].lt && !cell_flag[i+1].lt;
    end

    assign valid_vec[i] = cell_entry[i].valid;
    assign eq_vec[i]    = cell_flag[i].eq;

    tfsb_cell #(
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctl_i          (cell_ctl),
      .key_handle_i   (khandle_q),
      .left_entry_i   (left_entry),
      .left_handle_i  (left_handle),
      .left_flag_i    (left_flag),
      .right_entry_i  (right_entry),
      .right_handle_i (right_handle),
      .right_flag_i   (right_flag),
      .entry_o        (cell_entry[i]),
      .handle_o       (cell_handle[i]),
      .flag_o         (cell_flag[i])
    );
  end

  always_comb begin
    sel_below_stamp  = '0;
    sel_above_stamp  = '0;
    sel_below_handle = '0;
    sel_above_handle = '0;
    sel_hit_handle   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_below_stamp  = sel_below_stamp  | (below_oh[i] ? cell_entry[i].stamp : '0);
      sel_above_stamp  = sel_above_stamp  | (above_oh[i] ? cell_entry[i].stamp : '0);
      sel_below_handle = sel_below_handle | (below_oh[i] ? cell_handle[i] : '0);
      sel_above_handle = sel_above_handle | (above_oh[i] ? cell_handle[i] : '0);
      sel_hit_handle   = sel_hit_handle   | (eq_vec[i] ? cell_handle[i] : '0);
    end
  end

  assign hit_any  = |eq_vec;
  assign full     = valid_vec[DEPTH-1];
  assign lim_ext  = LW'(lim_q);
  assign eff_lim  = (lim_ext == '0) ? LW'(1) :
                    ((lim_ext > LW'(DEPTH)) ? LW'(DEPTH) : lim_ext);
  assign n_ext    = LW'(n_q);
  assign over_lim = n_ext > eff_lim;
  assign at_lim   = n_ext >= eff_lim;

  assign drain_go   = cell_entry[0].valid && (cell_entry[0].stamp <= res_stamp_q);
  assign pick_empty = !has_below_q && !has_above_q;
  // nearer below only when above - key > key - below
  assign pair_sum   = {1'b0, below_stamp_q} + {1'b0, above_stamp_q};
  assign pick_below = pair_sum > {key_q, 1'b0};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tfsb_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = tfsb_pkg::ST_DECIDE;
        end
      end
      tfsb_pkg::ST_DECIDE: begin
        if (kind_q == tfsb_pkg::KIND_SHOW) begin
          state_d = tfsb_pkg::ST_PICK;
        end else if (hit_any && over_lim) begin
          state_d = tfsb_pkg::ST_EVICT;
        end else begin
          state_d = tfsb_pkg::ST_DONE;
        end
      end
      tfsb_pkg::ST_PICK: begin
        state_d = (!hit_q && pick_empty) ? tfsb_pkg::ST_DONE : tfsb_pkg::ST_DRAIN;
      end
      tfsb_pkg::ST_DRAIN: begin
        if (!drain_go) begin
          state_d = tfsb_pkg::ST_DONE;
        end
      end
      tfsb_pkg::ST_EVICT: begin
        state_d = tfsb_pkg::ST_DONE;
      end
      tfsb_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tfsb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tfsb_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath control
  always_comb begin
    cell_op        = tfsb_pkg::OP_HOLD;
    n_d            = n_q;
    auto_d         = auto_q;
    lim_d          = cfg_we_i ? cfg_wdata_i : lim_q;
    res_status_d   = res_status_q;
    res_shown_d    = res_shown_q;
    res_stamp_d    = res_stamp_q;
    res_handle_d   = res_handle_q;
    hit_d          = hit_q;
    has_below_d    = has_below_q;
    has_above_d    = has_above_q;
    below_stamp_d  = below_stamp_q;
    above_stamp_d  = above_stamp_q;
    below_handle_d = below_handle_q;
    above_handle_d = above_handle_q;
    hit_handle_d   = hit_handle_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && out_stall_i;
    case (state_q)
      tfsb_pkg::ST_IDLE: begin
      end
      tfsb_pkg::ST_DECIDE: begin
        if (kind_q == tfsb_pkg::KIND_STORE) begin
          res_status_d = auto_q ? tfsb_pkg::STATUS_STORED_SHOWN : tfsb_pkg::STATUS_STORED;
          res_shown_d  = auto_q;
          res_stamp_d  = auto_q ? key_q : '0;
          res_handle_d = auto_q ? khandle_q : '0;
          if (hit_any) begin
            cell_op = tfsb_pkg::OP_SET_HANDLE;
          end else if (full || at_lim) begin
            // insert and drop the smallest in one pass
            cell_op = tfsb_pkg::OP_INS_LEFT;
          end else begin
            cell_op = tfsb_pkg::OP_INS_RIGHT;
            n_d     = n_q + CNT_W'(1);
          end
        end else begin
          auto_d         = 1'b0;
          hit_d          = hit_any;
          has_below_d    = |below_oh;
          has_above_d    = |above_oh;
          below_stamp_d  = sel_below_stamp;
          above_stamp_d  = sel_above_stamp;
          below_handle_d = sel_below_handle;
          above_handle_d = sel_above_handle;
          hit_handle_d   = sel_hit_handle;
        end
      end
      tfsb_pkg::ST_PICK: begin
        if (hit_q) begin
          res_status_d = tfsb_pkg::STATUS_EXACT;
          res_shown_d  = 1'b1;
          res_stamp_d  = key_q;
          res_handle_d = hit_handle_q;
        end else if (pick_empty) begin
          res_status_d = tfsb_pkg::STATUS_EMPTY;
          res_shown_d  = 1'b0;
          res_stamp_d  = '0;
          res_handle_d = '0;
        end else begin
          res_status_d = tfsb_pkg::STATUS_NEAREST;
          res_shown_d  = 1'b1;
          if (!has_above_q || (has_below_q && pick_below)) begin
            res_stamp_d  = below_stamp_q;
            res_handle_d = below_handle_q;
          end else begin
            res_stamp_d  = above_stamp_q;
            res_handle_d = above_handle_q;
          end
        end
      end
      tfsb_pkg::ST_DRAIN: begin
        if (drain_go) begin
          cell_op = tfsb_pkg::OP_SHIFT_LEFT;
          n_d     = n_q - CNT_W'(1);
        end
      end
      tfsb_pkg::ST_EVICT: begin
        cell_op = tfsb_pkg::OP_SHIFT_LEFT;
        n_d     = n_q - CNT_W'(1);
      end
      tfsb_pkg::ST_DONE: begin
        if (out_free) begin
          out_d.status       = res_status_q;
          out_d.shown        = res_shown_q;
          out_d.shown_stamp  = res_stamp_q;
          out_d.shown_handle = FHW'(res_handle_q);
          out_d.occupancy    = OCCW'(n_q);
          out_valid_d        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tfsb_pkg::ST_IDLE;
      auto_q      <= 1'b1;
      n_q         <= '0;
      lim_q       <= tfsb_pkg::LIMIT_RESET;
      hit_q       <= 1'b0;
      has_below_q <= 1'b0;
      has_above_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      auto_q      <= auto_d;
      n_q         <= n_d;
      lim_q       <= lim_d;
      hit_q       <= hit_d;
      has_below_q <= has_below_d;
      has_above_q <= has_above_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q    <= in_i.kind;
      key_q     <= in_i.stamp;
      khandle_q <= HANDLE_BITS'(in_i.frame_handle);
    end
    res_status_q   <= res_status_d;
    res_shown_q    <= res_shown_d;
    res_stamp_q    <= res_stamp_d;
    res_handle_q   <= res_handle_d;
    below_stamp_q  <= below_stamp_d;
    above_stamp_q  <= above_stamp_d;
    below_handle_q <= below_handle_d;
    above_handle_q <= above_handle_d;
    hit_handle_q   <= hit_handle_d;
    out_q          <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(n_q))
    else $error("occupancy count differs from valid cells");

  a_chain_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    else $error("valid cells not packed from cell 0");

  a_show_clears_auto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tfsb_pkg::ST_DECIDE && kind_q == tfsb_pkg::KIND_SHOW) |=> !auto_q)
    else $error("show request left auto-show set");

  a_shown_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.shown) |->
      (out_o.status != tfsb_pkg::STATUS_STORED && out_o.status != tfsb_pkg::STATUS_EMPTY))
    else $error("frame shown with a non-presenting status");

endmodule

@@ bench/tb_timestamp_frame_sync_buffer_core.sv @@
`timescale 1ns / 1ps
// Testbench for timestamp_frame_sync_buffer_core: directed and random transactions, predicted.
module tb_timestamp_frame_sync_buffer_core;

  localparam int unsigned DEPTH = 16;
  localparam logic [tfsb_pkg::STAMP_W-1:0] STAMP_MAX = {tfsb_pkg::STAMP_W{1'b1}};

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  tfsb_pkg::in_t              in_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  tfsb_pkg::out_t             out_o;
  logic                       cfg_we_i;
  logic [tfsb_pkg::CFG_W-1:0] cfg_wdata_i;

  timestamp_frame_sync_buffer_core #(
    .DEPTH      (DEPTH),
    .HANDLE_BITS(16)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  logic [tfsb_pkg::STAMP_W-1:0] held_stamp [DEPTH];
  logic [tfsb_pkg::FH_W-1:0]    held_handle [DEPTH];
  bit                           held_valid [DEPTH];
  bit                           auto_show;
  logic [tfsb_pkg::CFG_W-1:0]   limit_reg;

  tfsb_pkg::out_t               expected_results [$];
  int                           mismatch_count;
  bit                           quiet;
  int                           store_share;
  logic [tfsb_pkg::STAMP_W-1:0] base_stamp;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int min_slot();
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++)
      if (held_valid[i] && (best < 0 || held_stamp[i] < held_stamp[best])) best = i;
    return best;
  endfunction

  function automatic int held_count();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++)
      if (held_valid[i]) n++;
    return n;
  endfunction

  function automatic tfsb_pkg::out_t predict_result(tfsb_pkg::in_t item);
    tfsb_pkg::out_t               res;
    int                           hit;
    int                           free_slot;
    int                           m;
    int                           pick;
    int                           above;
    int                           below;
    int                           lim;
    bit                           full;
    logic [tfsb_pkg::STAMP_W-1:0] up;
    logic [tfsb_pkg::STAMP_W-1:0] down;
    logic [tfsb_pkg::STAMP_W-1:0] ps;
    res = '0;
    hit = -1;
    free_slot = -1;
    pick = -1;
    above = -1;
    below = -1;
    full = 1'b0;
    lim = (limit_reg == 0) ? 1 : (limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
    if (item.kind == tfsb_pkg::KIND_STORE) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (held_valid[i] && held_stamp[i] == item.stamp && hit < 0) hit = i;
        if (!held_valid[i] && free_slot < 0) free_slot = i;
      end
      if (hit >= 0) begin
        held_handle[hit] = item.frame_handle;
      end else if (free_slot >= 0) begin
        held_valid[free_slot] = 1'b1;
        held_stamp[free_slot] = item.stamp;
        held_handle[free_slot] = item.frame_handle;
      end else begin
        full = 1'b1;
        m = min_slot();
        if (m >= 0 && item.stamp > held_stamp[m]) begin
          held_stamp[m] = item.stamp;
          held_handle[m] = item.frame_handle;
        end
      end
      if (!full && held_count() > lim) begin
        m = min_slot();
        if (m >= 0) held_valid[m] = 1'b0;
      end
      if (auto_show) begin
        res.status = tfsb_pkg::STATUS_STORED_SHOWN;
        res.shown = 1'b1;
        res.shown_stamp = item.stamp;
        res.shown_handle = item.frame_handle;
      end else begin
        res.status = tfsb_pkg::STATUS_STORED;
      end
    end else begin
      auto_show = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        if (held_valid[i] && pick < 0) begin
          if (held_stamp[i] == item.stamp) begin
            pick = i;
          end else if (held_stamp[i] > item.stamp) begin
            if (above < 0 || held_stamp[i] < held_stamp[above]) above = i;
          end else begin
            if (below < 0 || held_stamp[i] > held_stamp[below]) below = i;
          end
        end
      end
      if (pick >= 0) begin
        res.status = tfsb_pkg::STATUS_EXACT;
      end else if (above < 0 && below < 0) begin
        res.status = tfsb_pkg::STATUS_EMPTY;
      end else begin
        res.status = tfsb_pkg::STATUS_NEAREST;
        if (above < 0) begin
          pick = below;
        end else if (below < 0) begin
          pick = above;
        end else begin
          up = held_stamp[above] - item.stamp;
          down = item.stamp - held_stamp[below];
          pick = (up > down) ? below : above;
        end
      end
      if (pick >= 0) begin
        ps = held_stamp[pick];
        res.shown = 1'b1;
        res.shown_stamp = ps;
        res.shown_handle = held_handle[pick];
        for (int i = 0; i < DEPTH; i++)
          if (held_valid[i] && held_stamp[i] <= ps) held_valid[i] = 1'b0;
      end
    end
    res.occupancy = tfsb_pkg::OCC_W'(held_count());
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // stamps follow a slowly rising window, with a few drawn from the full range
  function automatic tfsb_pkg::in_t random_item();
    tfsb_pkg::in_t item;
    int            r;
    r = $urandom_range(0, 99);
    item.frame_handle = tfsb_pkg::FH_W'($urandom);
    base_stamp = base_stamp + tfsb_pkg::STAMP_W'($urandom_range(0, 5));
    if (r < 5) begin
      item.kind = 1'($urandom);
      item.stamp = tfsb_pkg::STAMP_W'({$urandom, $urandom});
    end else if (r < store_share) begin
      item.kind = tfsb_pkg::KIND_STORE;
      item.stamp = base_stamp + tfsb_pkg::STAMP_W'($urandom_range(0, 48));
    end else begin
      item.kind = tfsb_pkg::KIND_SHOW;
      item.stamp = base_stamp + tfsb_pkg::STAMP_W'($urandom_range(0, 60));
    end
    return item;
  endfunction

  task automatic send_item(input tfsb_pkg::in_t item);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= item;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    expected_results.push_back(predict_result(item));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [tfsb_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_reg = value;
  endtask

  task automatic test_auto_show();
    write_limit(5'd16);
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_STORE, STAMP_MAX, 16'hFFFF});
    for (int i = 1; i <= 15; i++)
      send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_STORE, tfsb_pkg::STAMP_W'(i * 10),
                                tfsb_pkg::FH_W'($urandom)});
    // full store: below every stamp is dropped, above the minimum replaces it
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_STORE, 63'd5, 16'h0000});
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_STORE, 63'd200, 16'h5A5A});
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_STORE, 63'd20, 16'hA5A5});
  endtask

  task automatic test_limit_lowered();
    write_limit(5'd1);
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_STORE, 63'd40, 16'h1234});
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_STORE, 63'd30, 16'h4321});
  endtask

  task automatic test_show_requests();
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_SHOW, 63'd45, 16'hFFFF});
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_SHOW, 63'd130, 16'h0000});
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_SHOW, 63'd0, 16'h0000});
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_SHOW, 63'd1000, 16'h0000});
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_SHOW, STAMP_MAX, 16'h0000});
    send_item(tfsb_pkg::in_t'{tfsb_pkg::KIND_SHOW, 63'd77, 16'hFFFF});
  endtask

  task automatic test_random_phases();
    logic [tfsb_pkg::CFG_W-1:0] limits [8];
    limits = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd8, 5'd15, 5'd16};
    for (int p = 0; p < 8; p++) begin
      write_limit(p == 5 ? tfsb_pkg::CFG_W'($urandom) : limits[p]);
      quiet = (p == 2);
      store_share = (p % 2 == 0) ? 85 : 60;
      if (p == 6) base_stamp = STAMP_MAX - 63'd4000;
      repeat (170) send_item(random_item());
    end
    quiet = 1'b0;
  endtask

  task automatic test_drain_pause();
    store_share = 70;
    repeat (40) send_item(random_item());
    wait_idle();
    repeat (40) send_item(random_item());
  endtask

  initial begin
    int hold;
    out_stall_i = 1'b0;
    hold = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
        hold = pick_gap();
      end
    end
  end

  initial begin
    tfsb_pkg::out_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", out_o);
        end else begin
          want = expected_results.pop_front();
          if (out_o.status !== want.status || out_o.shown !== want.shown ||
              out_o.shown_stamp !== want.shown_stamp ||
              out_o.shown_handle !== want.shown_handle ||
              out_o.occupancy !== want.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: expected status %0d shown %0d stamp %h handle %h occ %0d, ",
                        "got status %0d shown %0d stamp %h handle %h occ %0d"},
                       want.status, want.shown, want.shown_stamp, want.shown_handle,
                       want.occupancy, out_o.status, out_o.shown, out_o.shown_stamp,
                       out_o.shown_handle, out_o.occupancy);
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_timestamp_frame_sync_buffer_core failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    mismatch_count = 0;
    quiet = 1'b0;
    store_share = 70;
    base_stamp = '0;
    for (int i = 0; i < DEPTH; i++) held_valid[i] = 1'b0;
    auto_show = 1'b1;
    limit_reg = tfsb_pkg::LIMIT_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_auto_show();
    test_limit_lowered();
    test_show_requests();
    test_random_phases();
    test_drain_pause();
    wait_idle();
    repeat (24) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_timestamp_frame_sync_buffer_core passed");
    end else begin
      $display("tb_timestamp_frame_sync_buffer_core failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tfsb_pkg.sv
rtl/tfsb_cell.sv
rtl/timestamp_frame_sync_buffer_core.sv
bench/tb_timestamp_frame_sync_buffer_core.sv
